// ===== hw/rtl/nearest_object_hit_search_assert.svh =====
// Assertion macros used by the checker file of nearest_object_hit_search.
// Every assertion is clocked on aclk and is off while aresetn is low.
`ifndef NEAREST_OBJECT_HIT_SEARCH_ASSERT_SVH
`define NEAREST_OBJECT_HIT_SEARCH_ASSERT_SVH

// Same-cycle implication: the consequent may itself start with a fixed delay.
`define NOHS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication.
`define NOHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/nohs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nohs_pkg
// Types, constants and the best-candidate merge shared by the search cells and
// the top level of the nearest object hit search.
// ----------------------------------------------------------------------------
package nohs_pkg;

    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int ID_W    = 9;
    localparam int DIST_W  = 14;
    localparam int CALC_W  = 18;
    localparam int ADDR_W  = 3;

    localparam logic signed [CALC_W-1:0] HIT_MARGIN = CALC_W'(8);
    localparam logic [DIST_W-1:0]        DIST_LIMIT = DIST_W'(10000);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Register index taken from the word address.
    localparam logic REG_USE_EXPANDED = 1'b0;

    typedef struct packed {
        logic                      used;
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } entry_t;

    // Query token that walks down the cell row. The candidate of the previous
    // cell rides along and is folded into the best result one cell later.
    typedef struct packed {
        logic                      valid;
        logic                      alive;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [DIST_W-1:0]         best_dist;
        logic [ID_W-1:0]           best_id;
        logic                      cand_valid;
        logic [DIST_W-1:0]         cand_dist;
        logic [ID_W-1:0]           cand_id;
    } token_t;

    function automatic token_t nohs_merge(input token_t t);
        token_t r;
        r = t;
        if (t.cand_valid && (t.cand_dist < t.best_dist)) begin
            r.best_dist = t.cand_dist;
            r.best_id   = t.cand_id;
        end
        r.cand_valid = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/nohs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nohs_cell
// One table slot of the search row: holds the slot's object, tests the passing
// query token against it and hands the token to the next cell.
// ----------------------------------------------------------------------------
module nohs_cell
    import nohs_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   use_expanded,
    input  wire logic   wr_en,
    input  wire entry_t wr_entry,
    input  wire token_t tok_in,
    output token_t      tok_out
);

    localparam logic [ID_W-1:0] CELL_ID = ID_W'(CELL_INDEX + 1);

    logic                      used_reg;
    logic signed [COORD_W-1:0] nx_reg, ny_reg, ex_reg, ey_reg;
    logic [SIZE_W-1:0]         w_reg, h_reg;
    token_t                    tok_reg;
    token_t                    tok_next;

    logic signed [CALC_W-1:0] ox, oy, wv, hv, half_w, half_h, px, py;
    logic signed [CALC_W-1:0] lo_x, hi_x, lo_y, hi_y, cx, cy;
    logic signed [CALC_W-1:0] dxp, dxn, dyp, dyn, dx, dy, cheb_dist;
    logic                     hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else if (wr_en) begin
            used_reg <= wr_entry.used;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            nx_reg <= wr_entry.nx;
            ny_reg <= wr_entry.ny;
            ex_reg <= wr_entry.ex;
            ey_reg <= wr_entry.ey;
            w_reg  <= wr_entry.w;
            h_reg  <= wr_entry.h;
        end
    end

    always_comb begin
        ox = use_expanded ? {{(CALC_W-COORD_W){ex_reg[COORD_W-1]}}, ex_reg}
                          : {{(CALC_W-COORD_W){nx_reg[COORD_W-1]}}, nx_reg};
        oy = use_expanded ? {{(CALC_W-COORD_W){ey_reg[COORD_W-1]}}, ey_reg}
                          : {{(CALC_W-COORD_W){ny_reg[COORD_W-1]}}, ny_reg};
        wv     = {{(CALC_W-SIZE_W){1'b0}}, w_reg};
        hv     = {{(CALC_W-SIZE_W){1'b0}}, h_reg};
        half_w = {{(CALC_W-SIZE_W+1){1'b0}}, w_reg[SIZE_W-1:1]};
        half_h = {{(CALC_W-SIZE_W+1){1'b0}}, h_reg[SIZE_W-1:1]};
        px = {{(CALC_W-COORD_W){tok_in.px[COORD_W-1]}}, tok_in.px};
        py = {{(CALC_W-COORD_W){tok_in.py[COORD_W-1]}}, tok_in.py};

        // The box widened by the margin on every side, right and bottom open.
        lo_x = ox - HIT_MARGIN;
        hi_x = ox + wv + HIT_MARGIN;
        lo_y = oy - HIT_MARGIN;
        hi_y = oy + hv + HIT_MARGIN;
        hit  = (px >= lo_x) && (px < hi_x) && (py >= lo_y) && (py < hi_y);

        // Both differences are formed side by side so the absolute value is
        // only a select.
        cx  = ox + half_w;
        cy  = oy + half_h;
        dxp = px - cx;
        dxn = cx - px;
        dyp = py - cy;
        dyn = cy - py;
        dx  = dxp[CALC_W-1] ? dxn : dxp;
        dy  = dyp[CALC_W-1] ? dyn : dyp;
        cheb_dist = (dy > dx) ? dy : dx;

        tok_next            = nohs_merge(tok_in);
        tok_next.alive      = tok_in.alive && used_reg;
        tok_next.cand_valid = tok_in.alive && used_reg && hit &&
                              (cheb_dist < {{(CALC_W-DIST_W){1'b0}}, DIST_LIMIT});
        tok_next.cand_dist  = cheb_dist[DIST_W-1:0];
        tok_next.cand_id    = CELL_ID;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/nearest_object_hit_search.sv =====
// A query token steps through the row of TABLE_DEPTH slot cells, one per cycle,
// on its way from acceptance to its result word.
// A table write returns a zero result word.
// One word is in flight at a time, so a new query or write is taken only once the
// last result is loaded for output; the next is taken while the result waits.
// Synchronous reset clears all used flags (one flop per cell).
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_object_hit_search
// Object table with a nearest-hit query, built as a row of slot cells that a
// query token walks through.
// ----------------------------------------------------------------------------
module nearest_object_hit_search
    import nohs_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_W-1:0]         paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,

    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_kind,
    input  wire logic [7:0]                s_entry_index,
    input  wire logic                      s_entry_used,
    input  wire logic signed [COORD_W-1:0] s_normal_x,
    input  wire logic signed [COORD_W-1:0] s_normal_y,
    input  wire logic signed [COORD_W-1:0] s_expanded_x,
    input  wire logic signed [COORD_W-1:0] s_expanded_y,
    input  wire logic [SIZE_W-1:0]         s_box_width,
    input  wire logic [SIZE_W-1:0]         s_box_height,
    input  wire logic signed [COORD_W-1:0] s_point_x,
    input  wire logic signed [COORD_W-1:0] s_point_y,

    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [ID_W-1:0]                m_closest_id
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [ID_W-1:0]      res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    logic [ID_W-1:0]      m_closest_id_reg;
    logic                 use_expanded_reg;

    logic                   s_fire;
    logic                   wr_fire;
    logic                   out_load;
    logic [TABLE_DEPTH-1:0] wr_sel;
    entry_t                 wr_entry;
    token_t                 tok_head;
    token_t                 tok [TABLE_DEPTH+1];
    token_t                 tok_final;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_expanded_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[ADDR_W-1] == REG_USE_EXPANDED)) begin
            use_expanded_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_USE_EXPANDED) ? {31'b0, use_expanded_reg}
                                                         : 32'b0;

    // Input side.
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign wr_fire = s_fire && (s_kind == KIND_WRITE);
    // Slots beyond the table shift out and select no cell.
    assign wr_sel  = TABLE_DEPTH'(1) << s_entry_index;

    assign wr_entry = '{used: s_entry_used, nx: s_normal_x, ny: s_normal_y,
                        ex: s_expanded_x, ey: s_expanded_y,
                        w: s_box_width, h: s_box_height};

    always_comb begin
        tok_head            = '0;
        tok_head.valid      = s_fire && (s_kind == KIND_QUERY);
        tok_head.alive      = 1'b1;
        tok_head.px         = s_point_x;
        tok_head.py         = s_point_y;
        tok_head.best_dist  = DIST_LIMIT;
        tok_head.best_id    = '0;
        tok_head.cand_valid = 1'b0;
    end

    assign tok[0] = tok_head;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        nohs_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .use_expanded (use_expanded_reg),
            .wr_en        (wr_fire && wr_sel[i]),
            .wr_entry     (wr_entry),
            .tok_in       (tok[i]),
            .tok_out      (tok[i+1])
        );
    end

    // The last cell's candidate still has to be folded in.
    assign tok_final = nohs_merge(tok[TABLE_DEPTH]);

    assign out_load = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_kind == KIND_WRITE) begin
                        res_next   = '0;
                        state_next = ST_HOLD;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (tok[TABLE_DEPTH].valid) begin
                    res_next   = tok_final.best_id;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (out_load) begin
            m_closest_id_reg <= res_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_closest_id = m_closest_id_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/nohs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nohs_checker
// Port-level assertions for nearest_object_hit_search, attached by bind.
// ----------------------------------------------------------------------------
`include "nearest_object_hit_search_assert.svh"

module nohs_checker
    import nohs_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_valid,
    input wire logic            s_ready,
    input wire logic            s_kind,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire logic [ID_W-1:0] m_closest_id
);

    // A stalled result word keeps its value.
    `NOHS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_closest_id), "result word changed while stalled")

    // Only one word is worked on at a time.
    `NOHS_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "input accepted while busy")

    // A table write into an empty output answers zero.
    `NOHS_ASSERT_IMPLY(a_write_zero, s_valid && s_ready && (s_kind == KIND_WRITE) && !m_valid, ##2 (m_valid && (m_closest_id == '0)), "write did not answer zero")

    // A reported slot never lies past the table.
    `NOHS_ASSERT_IMPLY(a_id_range, m_valid, ({23'b0, m_closest_id} <= 32'(TABLE_DEPTH)), "closest id beyond table")

endmodule

bind nearest_object_hit_search nohs_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_nohs_checker (.*);
`default_nettype wire
